// ===== rtl/bsn_pkg.sv =====
package bsn_pkg;

  localparam logic [5:0] MAX_SYNC_BITS = 6'd48;
  localparam logic [3:0] STUFF_RUN     = 4'd5;
  localparam logic [3:0] ONES_MAX      = 4'd15;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_SYNC_BITS  = 1'b0;
  localparam logic REG_DATA_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_SYNC  = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_STUFF = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_SYNC,
    PH_BIT
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic       line_level;
    logic [1:0] bit_kind;
    logic       last_of_item;
  } out_req_t;

  // classified byte as held in the queue between front and back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       flag;
  } item_t;

  typedef struct packed {
    logic [5:0]  sync_bits;
    logic [15:0] data_bit_limit;
  } cfg_t;

endpackage

// ===== rtl/bit_stuff_nrzi_frame_encoder_top.sv =====
// Bit-stuffing NRZI frame encoder.
// Input channel (in_valid_i / in_stall_o / in_req_i): one frame byte per
// request, with first_byte and last_byte marking the opening and closing
// flags. Output channel (out_valid_o / out_stall_i / out_req_o): one line
// bit per request, level plus kind, last_of_item set on the final bit of
// each byte. A byte that the data-bit limit cuts off entirely gives none.
// Registers on the APB port: sync_bits at 0x0, data_bit_limit at 0x4.
// A two-entry queue takes bytes while the bit sequencer is busy; the
// sequencer emits one line bit per cycle while the receiver does not stall;
// an opening flag first sends an init bit and max(1, sync_bits) sync bits (sync_bits clamped to 48).
// A byte cut off at its very first data bit emits no line bit at all.
// A request taken while idle goes through the queue, the sequencer and the output register.
// When the receiver stalls, the output register holds its bit and the
// sequencer waits; the queue fills and then in_stall_o rises.
// Reset empties the queue, sets the line level to 1, clears the run,
// bit count and limit state, and loads sync_bits = 16, limit = 0.
module bit_stuff_nrzi_frame_encoder_top import bsn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_req_t            in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_req_t           out_req_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg;
  logic  item_valid, item_pop;
  item_t item;

  bsn_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bsn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  bsn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_req_o    (out_req_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

// ===== rtl/bsn_cfg.sv =====
module bsn_cfg import bsn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [5:0]  sync_bits_q, sync_bits_d;
  logic [15:0] limit_q, limit_d;
  logic        wr_en;
  logic        reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    sync_bits_d = sync_bits_q;
    limit_d     = limit_q;
    if (wr_en) begin
      case (reg_sel)
        REG_SYNC_BITS:  sync_bits_d = pwdata[5:0];
        REG_DATA_LIMIT: limit_d     = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SYNC_BITS:  prdata = {26'd0, sync_bits_q};
      REG_DATA_LIMIT: prdata = {16'd0, limit_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_bits_q <= 6'd16;
      limit_q     <= 16'd0;
    end else begin
      sync_bits_q <= sync_bits_d;
      limit_q     <= limit_d;
    end
  end

  assign cfg_o.sync_bits      = sync_bits_q;
  assign cfg_o.data_bit_limit = limit_q;

endmodule

// ===== rtl/bsn_front.sv =====
module bsn_front import bsn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t in_req_i,
  output logic    item_valid_o,
  output item_t   item_o,
  input  logic    item_pop_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  item_t       cls;

  assign cls.data_byte = in_req_i.data_byte;
  assign cls.first     = in_req_i.first_byte;
  assign cls.flag      = in_req_i.first_byte | in_req_i.last_byte;

  assign in_stall_o   = cnt_q[1];
  assign push         = in_valid_i && !cnt_q[1];
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/bsn_back.sv =====
module bsn_back import bsn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     item_valid_i,
  input  item_t    item_i,
  output logic     item_pop_o,
  output logic     out_valid_o,
  output out_req_t out_req_o,
  input  logic     out_stall_i
);

  logic        active_q, active_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [5:0]  sync_left_q, sync_left_d;
  logic [7:0]  byte_q, byte_d;
  logic        flag_q, flag_d;
  logic        level_q, level_d;
  logic [3:0]  ones_q, ones_d;
  logic [15:0] count_q, count_d;
  logic        lim_q, lim_d;
  logic        out_valid_q, out_valid_d;
  out_req_t    out_q, out_d;

  logic        go, emit, nxt, nxt_is_slot, finishing;
  kind_e       kind;
  logic [5:0]  nsync;
  logic [15:0] cnt_inc;
  logic        cur_ok, inc_ok;
  logic        need_stuff, need_n, data_bit;
  logic [3:0]  ones_n;

  function automatic logic slot_ok(input logic [15:0] cnt, input logic lim,
                                   input logic [15:0] limit);
    slot_ok = !lim && !((limit != 16'd0) && (cnt >= limit));
  endfunction

  always_comb begin
    if (cfg_i.sync_bits == 6'd0)             nsync = 6'd1;
    else if (cfg_i.sync_bits > MAX_SYNC_BITS) nsync = MAX_SYNC_BITS;
    else                                      nsync = cfg_i.sync_bits;
  end

  assign go         = active_q && (!out_valid_q || !out_stall_i);
  assign cnt_inc    = (count_q == COUNT_MAX) ? count_q : count_q + 16'd1;
  assign cur_ok     = slot_ok(count_q, lim_q, cfg_i.data_bit_limit);
  assign inc_ok     = slot_ok(cnt_inc, lim_q, cfg_i.data_bit_limit);
  assign need_stuff = (ones_q >= STUFF_RUN) && !flag_q;
  assign data_bit   = byte_q[idx_q[2:0]];
  assign ones_n     = data_bit ? ((ones_q < ONES_MAX) ? ones_q + 4'd1 : ones_q) : 4'd0;
  assign need_n     = (ones_n >= STUFF_RUN) && !flag_q;

  always_comb begin
    active_d    = active_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    sync_left_d = sync_left_q;
    byte_d      = byte_q;
    flag_d      = flag_q;
    level_d     = level_q;
    ones_d      = ones_q;
    count_d     = count_q;
    lim_d       = lim_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    emit        = 1'b0;
    nxt         = 1'b0;
    nxt_is_slot = 1'b0;
    kind        = KIND_DATA;

    if (go) begin
      case (phase_q)
        PH_INIT: begin
          emit        = 1'b1;
          kind        = KIND_INIT;
          phase_d     = PH_SYNC;
          sync_left_d = nsync;
          nxt         = 1'b1;
        end
        PH_SYNC: begin
          emit        = 1'b1;
          kind        = KIND_SYNC;
          level_d     = ~level_q;
          sync_left_d = sync_left_q - 6'd1;
          if (sync_left_q == 6'd1) begin
            phase_d     = PH_BIT;
            idx_d       = 4'd0;
            nxt_is_slot = 1'b1;
            nxt         = cur_ok;
          end else begin
            nxt = 1'b1;
          end
        end
        PH_BIT: begin
          if (need_stuff) begin
            if (cur_ok) begin
              emit    = 1'b1;
              kind    = KIND_STUFF;
              level_d = ~level_q;
              ones_d  = 4'd0;
              count_d = cnt_inc;
              // after a stuffed bit the data bit at this position follows
              nxt_is_slot = (idx_q < BITS_PER_BYTE);
              nxt         = nxt_is_slot && inc_ok;
            end else begin
              lim_d = 1'b1;
            end
          end else if (idx_q < BITS_PER_BYTE) begin
            if (cur_ok) begin
              emit    = 1'b1;
              kind    = KIND_DATA;
              level_d = data_bit ? level_q : ~level_q;
              ones_d  = ones_n;
              count_d = cnt_inc;
              idx_d   = idx_q + 4'd1;
              if (idx_q != BITS_PER_BYTE - 4'd1) begin
                nxt_is_slot = 1'b1;
                nxt         = inc_ok;
              end else begin
                // trailing stuff only for non-flag bytes
                nxt_is_slot = need_n;
                nxt         = need_n && inc_ok;
              end
            end else begin
              lim_d = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (emit && nxt_is_slot && !nxt) lim_d = 1'b1;
      if (emit) begin
        out_valid_d           = 1'b1;
        out_d.line_level      = level_d;
        out_d.bit_kind        = kind;
        out_d.last_of_item    = !nxt;
      end else if (!out_stall_i) begin
        out_valid_d = 1'b0;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    finishing  = go && (!emit || !nxt);
    item_pop_o = item_valid_i && (!active_q || finishing);

    if (item_pop_o) begin
      active_d = 1'b1;
      byte_d   = item_i.data_byte;
      flag_d   = item_i.flag;
      idx_d    = 4'd0;
      if (item_i.first) begin
        phase_d = PH_INIT;
        level_d = 1'b1;
        ones_d  = 4'd0;
        count_d = 16'd0;
        lim_d   = 1'b0;
      end else begin
        phase_d = PH_BIT;
      end
    end else if (finishing) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      phase_q     <= PH_BIT;
      idx_q       <= 4'd0;
      sync_left_q <= 6'd0;
      level_q     <= 1'b1;
      ones_q      <= 4'd0;
      count_q     <= 16'd0;
      lim_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      sync_left_q <= sync_left_d;
      level_q     <= level_d;
      ones_q      <= ones_d;
      count_q     <= count_d;
      lim_q       <= lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    flag_q <= flag_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== tb/bit_stuff_nrzi_frame_encoder_top_tb.sv =====
module bit_stuff_nrzi_frame_encoder_top_tb;
  import bsn_pkg::*;

  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 15;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_req_t            in_req_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_req_t           out_req_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  bit_stuff_nrzi_frame_encoder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  in_req_t  byte_q[$];   // bytes waiting to be offered
  out_req_t line_q[$];   // predicted line bits, oldest first

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  drain_mode     = 1'b0;
  bit  in_taken       = 1'b0;
  int  err_cnt        = 0;
  int  quiet_cycles   = 0;

  // encoder shadow state
  logic [5:0]  sync_cfg   = 6'd16;
  logic [15:0] limit_cfg  = 16'd0;
  logic        line_lvl   = 1'b1;
  logic [3:0]  run_len    = 4'd0;
  logic [15:0] frame_bits = 16'd0;
  logic        frame_cut  = 1'b0;
  out_req_t    staged;
  bit          have_staged = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // Hold back each bit by one so the final bit of a byte can be marked.
  function automatic void stage_bit(input kind_e k);
    if (have_staged) line_q.push_back(staged);
    staged.line_level   = line_lvl;
    staged.bit_kind     = k;
    staged.last_of_item = 1'b0;
    have_staged = 1'b1;
  endfunction

  function automatic logic take_slot();
    if (frame_cut) return 1'b0;
    if (limit_cfg != 16'd0 && frame_bits >= limit_cfg) begin
      frame_cut = 1'b1;
      return 1'b0;
    end
    if (frame_bits != COUNT_MAX) frame_bits++;
    return 1'b1;
  endfunction

  function automatic void encode_byte(input in_req_t r);
    logic flag;
    logic cut;
    int   nsync;
    flag = r.first_byte | r.last_byte;
    cut  = 1'b0;
    if (r.first_byte) begin
      line_lvl   = 1'b1;
      run_len    = 4'd0;
      frame_bits = 16'd0;
      frame_cut  = 1'b0;
      nsync = (sync_cfg == 6'd0) ? 1 : (sync_cfg > MAX_SYNC_BITS) ? int'(MAX_SYNC_BITS)
                                                                    : int'(sync_cfg);
      stage_bit(KIND_INIT);
      for (int k = 0; k < nsync; k++) begin
        line_lvl = ~line_lvl;
        stage_bit(KIND_SYNC);
      end
    end
    for (int i = 0; i < BITS_PER_BYTE && !cut; i++) begin
      if (run_len >= STUFF_RUN && !flag) begin
        if (!take_slot()) begin
          cut = 1'b1;
        end else begin
          line_lvl = ~line_lvl;
          run_len  = 4'd0;
          stage_bit(KIND_STUFF);
        end
      end
      if (!cut) begin
        if (!take_slot()) begin
          cut = 1'b1;
        end else begin
          if (r.data_byte[i]) begin
            if (run_len != ONES_MAX) run_len++;
          end else begin
            line_lvl = ~line_lvl;
            run_len  = 4'd0;
          end
          stage_bit(KIND_DATA);
        end
      end
    end
    // trailing run of a non-flag byte is stuffed within that byte
    if (!cut && run_len >= STUFF_RUN && !flag) begin
      if (take_slot()) begin
        line_lvl = ~line_lvl;
        run_len  = 4'd0;
        stage_bit(KIND_STUFF);
      end
    end
    if (have_staged) begin
      staged.last_of_item = 1'b1;
      line_q.push_back(staged);
      have_staged = 1'b0;
    end
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(drain_mode && byte_q[0].first_byte && line_q.size() != 0)) begin
        in_req_i   <= byte_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    out_req_t e;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) encode_byte(in_req_i);
      if (out_valid_o && !out_stall_i) begin
        if (line_q.size() == 0) begin
          report_mismatch($sformatf("unexpected line bit %p", out_req_o));
        end else begin
          e = line_q.pop_front();
          if (out_req_o.line_level !== e.line_level ||
              out_req_o.bit_kind !== e.bit_kind ||
              out_req_o.last_of_item !== e.last_of_item) begin
            report_mismatch($sformatf("got lvl %b kind %0d last %b, want lvl %b kind %0d last %b",
                                      out_req_o.line_level, out_req_o.bit_kind,
                                      out_req_o.last_of_item, e.line_level, e.bit_kind,
                                      e.last_of_item));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i)) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[bit_stuff_nrzi_frame_encoder_top] ERROR");
      $finish;
    end
  end

  task automatic set_reg(input logic reg_idx, input logic [15:0] value);
    logic [PADDR_W-1:0] addr;
    logic [31:0]        rd;
    addr = {reg_idx, 2'b00};
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= (reg_idx == REG_SYNC_BITS) ? {26'd0, value[5:0]} : {16'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_idx == REG_SYNC_BITS) begin
      sync_cfg = value[5:0];
      if (rd[5:0] !== value[5:0])
        report_mismatch($sformatf("sync_bits reads %0h, wrote %0h", rd[5:0], value[5:0]));
    end else begin
      limit_cfg = value;
      if (rd[15:0] !== value)
        report_mismatch($sformatf("data_bit_limit reads %0h, wrote %0h", rd[15:0], value));
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid_i || line_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic first, input logic last);
    in_req_t r;
    r.data_byte  = b;
    r.first_byte = first;
    r.last_byte  = last;
    byte_q.push_back(r);
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(3))
      0:       return 8'hFF;
      1:       return 8'($urandom | $urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_frame();
    int n;
    n = $urandom_range(4);
    push_byte(8'($urandom), 1'b1, ($urandom_range(9) == 0));
    for (int k = 0; k < n; k++) push_byte(rand_data(), 1'b0, 1'b0);
    push_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct, input bit drain);
    logic [15:0] s;
    logic [15:0] lim;
    case ($urandom_range(4))
      0:       s = 16'd0;
      1:       s = 16'd1;
      2:       s = 16'(MAX_SYNC_BITS);
      3:       s = 16'd63;
      default: s = 16'($urandom_range(12));
    endcase
    case ($urandom_range(4))
      0, 1:    lim = 16'd0;
      2:       lim = 16'($urandom_range(120, 1));
      3:       lim = 16'd1;
      default: lim = ($urandom_range(1) == 0) ? COUNT_MAX : 16'($urandom_range(400, 1));
    endcase
    set_reg(REG_SYNC_BITS, s);
    set_reg(REG_DATA_LIMIT, lim);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    drain_mode     = drain;
    while (byte_q.size() < PHASE_ITEMS) begin
      if ($urandom_range(99) < 15) begin
        push_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        queue_frame();
      end
    end
    wait_drained();
    drain_mode = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config: bytes before any frame, flags, stuffing across flag bytes
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h7E, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h1F, 1'b0, 1'b0);
    push_byte(8'hF8, 1'b0, 1'b0);
    push_byte(8'h7E, 1'b0, 1'b1);
    push_byte(8'hA5, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);   // ones run saturates in flags
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'hC3, 1'b1, 1'b1);
    wait_drained();

    set_reg(REG_SYNC_BITS, 16'd0);
    set_reg(REG_DATA_LIMIT, 16'd1);
    push_byte(8'h55, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h7E, 1'b0, 1'b1);
    wait_drained();

    // limit cuts the all-ones byte before its last data bit, then cuts a whole byte
    set_reg(REG_SYNC_BITS, 16'd1);
    set_reg(REG_DATA_LIMIT, 16'd16);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0);
    wait_drained();

    set_reg(REG_SYNC_BITS, 16'(MAX_SYNC_BITS));
    set_reg(REG_DATA_LIMIT, 16'd9);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    wait_drained();

    set_reg(REG_SYNC_BITS, 16'd63);
    set_reg(REG_DATA_LIMIT, COUNT_MAX);
    push_byte(8'h3C, 1'b1, 1'b0);
    push_byte(8'hFE, 1'b0, 1'b1);
    wait_drained();

    random_phase(0, 0, 1'b1);
    random_phase(85, 0, 1'b0);
    random_phase(0, 85, 1'b0);
    random_phase(27, 27, 1'b0);
    random_phase(0, 0, 1'b0);

    if (err_cnt == 0) begin
      $display("[bit_stuff_nrzi_frame_encoder_top] OK");
    end else begin
      $display("[bit_stuff_nrzi_frame_encoder_top] ERROR");
    end
    $finish;
  end

endmodule
